@@ rtl/cpu_alu_with_flags_unit_defines.svh @@
// Assertion macros for the ALU block
`ifndef CPU_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_UNIT_DEFINES_SVH

// Check a property while out of reset
`define CAFU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included
`define CAFU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/cafu_pkg.sv @@
package cafu_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLC   = 5'd10,
        OP_RL    = 5'd11,
        OP_RRC   = 5'd12,
        OP_RR    = 5'd13,
        OP_SLA   = 5'd14,
        OP_SRA   = 5'd15,
        OP_SRL   = 5'd16,
        OP_SWAP  = 5'd17,
        OP_BIT   = 5'd18,
        OP_RES   = 5'd19,
        OP_SET   = 5'd20,
        OP_ADD16 = 5'd21,
        OP_INC16 = 5'd22
    } alu_op_t;

    localparam int unsigned IN_BITS  = 40;
    localparam int unsigned OUT_BITS = 24;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    // op sits in the lowest bits
    typedef struct packed {
        logic [2:0]  bit_index;
        logic [15:0] operand_b;
        logic [15:0] operand_a;
        alu_op_t     op;
    } item_t;

endpackage

@@ rtl/cpu_alu_with_flags_unit.sv @@
// Channel   Dir  Word bits (lowest first)
// s_axis    in   op[4:0] operand_a[20:5] operand_b[36:21] bit_index[39:37]
// m_axis    out  result[15:0] zero[16] subtract[17] half[18] carry[19] zero pad[23:20]
//
// One word a cycle while m_axis_tready holds; a word passes input, then result register.
// The input register feeds the ALU; the flag register updates as the result register loads.
// Reset (rst_n low, asynchronous) empties both registers and clears the flags.
// A stalled result register holds the input register, and s_axis_tready drops once both fill.
`include "cpu_alu_with_flags_unit_defines.svh"

module cpu_alu_with_flags_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // op, operand_a, operand_b, bit_index
    input  logic [cafu_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result, zero_flag, subtract_flag, half_flag, carry_out_flag, pad
    output logic [cafu_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import cafu_pkg::*;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic [15:0] out_result_reg;
    flags_t      out_flags_reg;
    flags_t      flags_reg;
    logic [15:0] alu_result;
    flags_t      alu_flags;
    logic        advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    cafu_alu u_alu (
        .item      (in_item_reg),
        .flags_in  (flags_reg),
        .result    (alu_result),
        .flags_out (alu_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= alu_flags;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= item_t'(s_axis_tdata);
        end
        if (advance)
        begin
            out_result_reg <= alu_result;
            out_flags_reg  <= alu_flags;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_flags_reg.c, out_flags_reg.h,
                            out_flags_reg.n, out_flags_reg.z, out_result_reg};

    `CAFU_ASSERT(a_flags_hold, !advance |=> $stable(flags_reg), "flags changed without a word")
    `CAFU_ASSERT(a_flags_match, out_valid_reg |-> (out_flags_reg == flags_reg), "flags mismatch")
    `CAFU_ASSERT(a_ready_when_empty, !in_valid_reg |-> s_axis_tready, "input blocked while empty")
    `CAFU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!m_axis_tvalid && !in_valid_reg), "valid in reset")

endmodule

@@ rtl/cafu_alu.sv @@
module cafu_alu (
    input  cafu_pkg::item_t  item,
    input  cafu_pkg::flags_t flags_in,
    output logic [15:0]      result,
    output cafu_pkg::flags_t flags_out
);
    import cafu_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic        cuse;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [8:0]  dif9;
    logic [4:0]  dif5;
    logic [7:0]  r8;
    logic [7:0]  mask;
    logic [16:0] sum17;
    logic [12:0] sum13;

    always_comb
    begin
        a     = item.operand_a[7:0];
        b     = item.operand_b[7:0];
        cin   = flags_in.c;
        cuse  = ((item.op == OP_ADC) || (item.op == OP_SBC)) ? cin : 1'b0;
        sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cuse};
        sum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
        dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cuse};
        dif5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};
        mask  = 8'd1 << item.bit_index;
        sum17 = {1'b0, item.operand_a} + {1'b0, item.operand_b};
        sum13 = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};
        r8    = 8'd0;
        result    = item.operand_a;
        flags_out = flags_in;
        case (item.op)
            OP_ADD, OP_ADC:
            begin
                r8 = sum9[7:0];
                flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: sum5[4], c: sum9[8]};
                result = {8'd0, r8};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                r8 = dif9[7:0];
                flags_out = '{z: (r8 == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
                result = (item.op == OP_CP) ? item.operand_a : {8'd0, r8};
            end
            OP_AND:
            begin
                r8 = a & b;
                flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
                result = {8'd0, r8};
            end
            OP_OR, OP_XOR, OP_SWAP:
            begin
                case (item.op)
                    OP_OR:   r8 = a | b;
                    OP_XOR:  r8 = a ^ b;
                    default: r8 = {a[3:0], a[7:4]};
                endcase
                flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
                result = {8'd0, r8};
            end
            OP_INC:
            begin
                r8 = a + 8'd1;
                flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: (r8[3:0] == 4'h0), c: cin};
                result = {8'd0, r8};
            end
            OP_DEC:
            begin
                r8 = a - 8'd1;
                flags_out = '{z: (r8 == 8'd0), n: 1'b1, h: (r8[3:0] == 4'hF), c: cin};
                result = {8'd0, r8};
            end
            OP_RLC, OP_RL, OP_SLA:
            begin
                case (item.op)
                    OP_RLC:  r8 = {a[6:0], a[7]};
                    OP_RL:   r8 = {a[6:0], cin};
                    default: r8 = {a[6:0], 1'b0};
                endcase
                flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
                result = {8'd0, r8};
            end
            OP_RRC, OP_RR, OP_SRA, OP_SRL:
            begin
                case (item.op)
                    OP_RRC:  r8 = {a[0], a[7:1]};
                    OP_RR:   r8 = {cin, a[7:1]};
                    OP_SRA:  r8 = {a[7], a[7:1]};
                    default: r8 = {1'b0, a[7:1]};
                endcase
                flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
                result = {8'd0, r8};
            end
            OP_BIT:
            begin
                flags_out = '{z: ((a & mask) == 8'd0), n: 1'b0, h: 1'b1, c: cin};
            end
            OP_RES:
            begin
                result = {8'd0, a & ~mask};
            end
            OP_SET:
            begin
                result = {8'd0, a | mask};
            end
            OP_ADD16:
            begin
                result = sum17[15:0];
                flags_out = '{z: flags_in.z, n: 1'b0, h: sum13[12], c: sum17[16]};
            end
            OP_INC16:
            begin
                result = item.operand_a + 16'd1;
            end
            default:
            begin
                result = item.operand_a;
            end
        endcase
    end

endmodule
